@@ sv/handle_allocator_free_stack_assert.svh @@
// assertion macros shared by the handle allocator modules
// expects signals named clk and rst_n in the including module
`ifndef HANDLE_ALLOCATOR_FREE_STACK_ASSERT_SVH
`define HANDLE_ALLOCATOR_FREE_STACK_ASSERT_SVH

// property that must hold in every cycle outside reset
`define HAFS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("handle allocator assertion failed");

// consequence must hold in the cycle after the antecedent
`define HAFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle allocator assertion failed");

`endif

@@ sv/hafs_pkg.sv @@
// shared types and constants for the handle allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hafs_pkg;

    localparam int unsigned HANDLE_W           = 32;
    localparam int unsigned CMD_W              = 3;
    localparam int unsigned STATUS_W           = 2;
    localparam int unsigned RELEASED_DEPTH_DEF = 64;
    localparam int unsigned RESERVED_DEPTH_DEF = 16;

    localparam logic [HANDLE_W-1:0] MAX_HANDLE_RST = '1;
    localparam logic [HANDLE_W-1:0] FIRST_HANDLE   = HANDLE_W'(1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BASE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REL_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RES_FULL = 2'd2;

    // datapath operations issued by the controller
    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic ridx_clr;
        logic ridx_inc;
        logic rel_rd;
        logic rel_rd_last;
        logic rel_pop;
        logic rel_move;
        logic rel_push;
        logic res_push;
        logic res_rd;
        logic nh_inc;
        logic nh_max;
        logic clear;
        logic drop_below;
        logic result_pop;
        logic result_nh;
        logic out_load;
    } dp_ops_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic rel_empty;
        logic idx_lt_count;
        logic ridx_lt_count;
        logic rel_hit;
        logic res_hit;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/hafs_datapath.sv @@
// datapath: handle counter, released stack and reserved list memories, result register
// depends on hafs_pkg and handle_allocator_free_stack_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "handle_allocator_free_stack_assert.svh"

module hafs_datapath #(
    parameter int unsigned RELEASED_DEPTH = hafs_pkg::RELEASED_DEPTH_DEF,
    parameter int unsigned RESERVED_DEPTH = hafs_pkg::RESERVED_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [hafs_pkg::HANDLE_W-1:0]     handle_in,
    input  wire hafs_pkg::dp_ops_t                 ops,
    output hafs_pkg::dp_stat_t                     stat,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hafs_pkg::HANDLE_W-1:0]     cfg_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [hafs_pkg::HANDLE_W-1:0]          m_tdata,
    output logic [hafs_pkg::STATUS_W:0]            m_tuser
);
    import hafs_pkg::*;

    localparam int unsigned RCW = $clog2(RELEASED_DEPTH + 1);
    localparam int unsigned RAW = (RELEASED_DEPTH > 1) ? $clog2(RELEASED_DEPTH) : 1;
    localparam int unsigned VCW = $clog2(RESERVED_DEPTH + 1);
    localparam int unsigned VAW = (RESERVED_DEPTH > 1) ? $clog2(RESERVED_DEPTH) : 1;

    logic [HANDLE_W-1:0] rel_mem [RELEASED_DEPTH];
    logic [HANDLE_W-1:0] res_mem [RESERVED_DEPTH];
    logic [HANDLE_W-1:0] rel_rd_data;
    logic [HANDLE_W-1:0] res_rd_data;

    logic [RCW-1:0]      rel_count_reg, rel_count_next;
    logic [RCW-1:0]      rel_idx_reg, rel_idx_next;
    logic [VCW-1:0]      res_count_reg, res_count_next;
    logic [VCW-1:0]      res_idx_reg, res_idx_next;
    logic [HANDLE_W-1:0] nh_reg, nh_next;
    logic [HANDLE_W-1:0] max_reg, max_next;
    logic [HANDLE_W-1:0] h_reg;
    logic [HANDLE_W-1:0] result_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0] out_data_reg;
    logic [STATUS_W:0]   out_user_reg;

    logic [RCW-1:0]      rel_last_full;
    logic [RAW-1:0]      rel_rd_addr;
    logic                rel_space;
    logic                res_space;
    logic                avail;

    assign rel_space     = rel_count_reg < RCW'(RELEASED_DEPTH);
    assign res_space     = res_count_reg < VCW'(RESERVED_DEPTH);
    assign rel_last_full = rel_count_reg - RCW'(1);
    assign rel_rd_addr   = ops.rel_rd_last ? rel_last_full[RAW-1:0] : rel_idx_reg[RAW-1:0];
    assign avail         = (rel_count_reg != '0) || (nh_reg < max_reg);

    // status toward the controller
    always_comb
    begin
        stat.rel_empty     = (rel_count_reg == '0);
        stat.idx_lt_count  = rel_idx_reg < rel_count_reg;
        stat.ridx_lt_count = res_idx_reg < res_count_reg;
        stat.rel_hit       = ops.drop_below ? (rel_rd_data < h_reg) : (rel_rd_data == h_reg);
        stat.res_hit       = (res_rd_data == nh_reg);
        stat.out_free      = !out_valid_reg || m_tready;
    end

    // released stack memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (ops.rel_move)
        begin
            rel_mem[rel_idx_reg[RAW-1:0]] <= rel_rd_data;
        end
        else if (ops.rel_push && rel_space && (h_reg <= nh_reg))
        begin
            rel_mem[rel_count_reg[RAW-1:0]] <= h_reg;
        end
        if (ops.rel_rd)
        begin
            rel_rd_data <= rel_mem[rel_rd_addr];
        end
    end

    // reserved list memory
    always_ff @(posedge clk)
    begin
        if (ops.res_push && res_space)
        begin
            res_mem[res_count_reg[VAW-1:0]] <= h_reg;
        end
        if (ops.res_rd)
        begin
            res_rd_data <= res_mem[res_idx_reg[VAW-1:0]];
        end
    end

    // counters and handle counter next values
    always_comb
    begin
        rel_count_next = rel_count_reg;
        if (ops.clear)
        begin
            rel_count_next = '0;
        end
        else if (ops.rel_pop || ops.rel_move)
        begin
            rel_count_next = rel_count_reg - RCW'(1);
        end
        else if (ops.rel_push && rel_space && (h_reg <= nh_reg))
        begin
            rel_count_next = rel_count_reg + RCW'(1);
        end

        rel_idx_next = rel_idx_reg;
        if (ops.idx_clr)
        begin
            rel_idx_next = '0;
        end
        else if (ops.idx_inc)
        begin
            rel_idx_next = rel_idx_reg + RCW'(1);
        end

        res_count_next = res_count_reg;
        if (ops.clear)
        begin
            res_count_next = '0;
        end
        else if (ops.res_push && res_space)
        begin
            res_count_next = res_count_reg + VCW'(1);
        end

        res_idx_next = res_idx_reg;
        if (ops.ridx_clr)
        begin
            res_idx_next = '0;
        end
        else if (ops.ridx_inc)
        begin
            res_idx_next = res_idx_reg + VCW'(1);
        end

        nh_next = nh_reg;
        if (ops.clear)
        begin
            nh_next = FIRST_HANDLE;
        end
        else if (ops.nh_inc)
        begin
            nh_next = nh_reg + HANDLE_W'(1);
        end
        else if (ops.nh_max && (h_reg > nh_reg))
        begin
            nh_next = h_reg;
        end

        max_next = max_reg;
        if (cfg_valid)
        begin
            max_next = cfg_data;
        end

        out_valid_next = out_valid_reg;
        if (ops.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_count_reg <= '0;
            rel_idx_reg   <= '0;
            res_count_reg <= '0;
            res_idx_reg   <= '0;
            nh_reg        <= FIRST_HANDLE;
            max_reg       <= MAX_HANDLE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rel_count_reg <= rel_count_next;
            rel_idx_reg   <= rel_idx_next;
            res_count_reg <= res_count_next;
            res_idx_reg   <= res_idx_next;
            nh_reg        <= nh_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // operand, result and output word registers
    always_ff @(posedge clk)
    begin
        if (ops.load)
        begin
            h_reg      <= handle_in;
            result_reg <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (ops.result_pop)
            begin
                result_reg <= rel_rd_data;
            end
            else if (ops.result_nh)
            begin
                result_reg <= nh_reg;
            end
            if (ops.rel_push && !rel_space && (h_reg <= nh_reg))
            begin
                status_reg <= ST_REL_FULL;
            end
            else if (ops.res_push && !res_space)
            begin
                status_reg <= ST_RES_FULL;
            end
        end
        if (ops.out_load)
        begin
            out_data_reg <= result_reg;
            out_user_reg <= {status_reg, avail};
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    `HAFS_ASSERT(a_rel_count_bound, rel_count_reg <= RCW'(RELEASED_DEPTH))
    `HAFS_ASSERT(a_res_count_bound, res_count_reg <= VCW'(RESERVED_DEPTH))
    `HAFS_ASSERT(a_move_nonempty, !(ops.rel_move || ops.rel_pop) || (rel_count_reg != '0))
    `HAFS_ASSERT_NEXT(a_out_loaded, ops.out_load, out_valid_reg)

endmodule

`default_nettype wire

@@ sv/hafs_controller.sv @@
// controller state machine sequencing the scans of the handle allocator
// depends on hafs_pkg and handle_allocator_free_stack_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "handle_allocator_free_stack_assert.svh"

module hafs_controller (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [hafs_pkg::CMD_W-1:0]    command,
    input  wire hafs_pkg::dp_stat_t            stat,
    output hafs_pkg::dp_ops_t                  ops
);
    import hafs_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_POP_RD    = 12'b0000_0000_0010,
        S_POP_WAIT  = 12'b0000_0000_0100,
        S_RES_RD    = 12'b0000_0000_1000,
        S_RES_CHK   = 12'b0000_0001_0000,
        S_RES_PUSH  = 12'b0000_0010_0000,
        S_BASE      = 12'b0000_0100_0000,
        S_DROP_RD   = 12'b0000_1000_0000,
        S_DROP_CHK  = 12'b0001_0000_0000,
        S_DROP_MOVE = 12'b0010_0000_0000,
        S_PUSH      = 12'b0100_0000_0000,
        S_FINISH    = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic              accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // next state and datapath operations
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ops            = '0;
        ops.drop_below = (cmd_reg == CMD_BASE);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = command;
                    ops.load     = 1'b1;
                    ops.idx_clr  = 1'b1;
                    ops.ridx_clr = 1'b1;
                    case (command)
                        CMD_ALLOC:   state_next = stat.rel_empty ? S_RES_RD : S_POP_RD;
                        CMD_RELEASE: state_next = S_DROP_RD;
                        CMD_RESERVE: state_next = S_RES_PUSH;
                        CMD_BASE:    state_next = S_BASE;
                        CMD_CLEAR:
                        begin
                            ops.clear  = 1'b1;
                            state_next = S_FINISH;
                        end
                        default:     state_next = S_FINISH;
                    endcase
                end
            end
            S_POP_RD:
            begin
                ops.rel_rd      = 1'b1;
                ops.rel_rd_last = 1'b1;
                ops.rel_pop     = 1'b1;
                state_next      = S_POP_WAIT;
            end
            S_POP_WAIT:
            begin
                ops.result_pop = 1'b1;
                state_next     = S_FINISH;
            end
            // walk the reserved list until the counter value is free
            S_RES_RD:
            begin
                if (stat.ridx_lt_count)
                begin
                    ops.res_rd = 1'b1;
                    state_next = S_RES_CHK;
                end
                else
                begin
                    ops.result_nh = 1'b1;
                    ops.nh_inc    = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_RES_CHK:
            begin
                if (stat.res_hit)
                begin
                    ops.nh_inc   = 1'b1;
                    ops.ridx_clr = 1'b1;
                end
                else
                begin
                    ops.ridx_inc = 1'b1;
                end
                state_next = S_RES_RD;
            end
            S_RES_PUSH:
            begin
                ops.res_push = 1'b1;
                state_next   = S_DROP_RD;
            end
            S_BASE:
            begin
                ops.nh_max = 1'b1;
                state_next = S_DROP_RD;
            end
            // removal scan over the released stack
            S_DROP_RD:
            begin
                if (stat.idx_lt_count)
                begin
                    ops.rel_rd = 1'b1;
                    state_next = S_DROP_CHK;
                end
                else
                begin
                    state_next = (cmd_reg == CMD_RELEASE) ? S_PUSH : S_FINISH;
                end
            end
            S_DROP_CHK:
            begin
                if (stat.rel_hit)
                begin
                    ops.rel_rd      = 1'b1;
                    ops.rel_rd_last = 1'b1;
                    state_next      = S_DROP_MOVE;
                end
                else
                begin
                    ops.idx_inc = 1'b1;
                    state_next  = S_DROP_RD;
                end
            end
            S_DROP_MOVE:
            begin
                ops.rel_move = 1'b1;
                state_next   = S_DROP_RD;
            end
            S_PUSH:
            begin
                ops.rel_push = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ops.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= CMD_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

    `HAFS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != S_IDLE)
    `HAFS_ASSERT(a_single_write, !(ops.rel_move && ops.rel_push))
    `HAFS_ASSERT_NEXT(a_finish_done, (state_reg == S_FINISH) && stat.out_free,
        state_reg == S_IDLE)

endmodule

`default_nettype wire

@@ sv/handle_allocator_free_stack.sv @@
// top level of the handle allocator with released-handle stack
// depends on hafs_pkg, hafs_controller, hafs_datapath
//
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  tdata handle_in, tuser command
// m_axis    out  m_tvalid/m_tready  tdata handle_out, tuser available, status
// cfg       in   cfg_valid/cfg_ready cfg_data max_handle
//
// one command at a time; allocate pops the top of the released stack, or if it is empty takes the counter,
// probing every reserved entry and stepping the counter and restarting the probe on each reserved hit
// release, reserve and set_base scan the released stack
// the result sits in an output register, so the next word is taken while it waits
// reset clears the counts, the counter to 1 and max_handle to all ones
`timescale 1ns / 1ps
`default_nettype none

module handle_allocator_free_stack #(
    parameter int unsigned RELEASED_DEPTH = hafs_pkg::RELEASED_DEPTH_DEF,
    parameter int unsigned RESERVED_DEPTH = hafs_pkg::RESERVED_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [hafs_pkg::HANDLE_W-1:0]     s_tdata,   // handle_in
    input  wire logic [hafs_pkg::CMD_W-1:0]        s_tuser,   // command
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [hafs_pkg::HANDLE_W-1:0]          m_tdata,   // handle_out
    output logic [hafs_pkg::STATUS_W:0]            m_tuser,   // available, status
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hafs_pkg::HANDLE_W-1:0]     cfg_data   // max_handle
);
    import hafs_pkg::*;

    dp_ops_t  ops;
    dp_stat_t stat;

    hafs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .stat     (stat),
        .ops      (ops)
    );

    hafs_datapath #(
        .RELEASED_DEPTH (RELEASED_DEPTH),
        .RESERVED_DEPTH (RESERVED_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .handle_in (s_tdata),
        .ops       (ops),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
